@@ rtl/core/wbbm_pkg.sv @@
// Shared constants, codes and widths for the write buffer batch manager.
`default_nettype none
package wbbm_pkg;
	localparam int BATCH_COUNT   = 16;
	localparam int BATCH_ENTRIES = 8;
	localparam int TOTAL_ENTRIES = BATCH_COUNT * BATCH_ENTRIES;

	localparam int BW     = $clog2(BATCH_COUNT);        // batch number
	localparam int EW     = $clog2(TOTAL_ENTRIES);      // entry position
	localparam int FCNT_W = $clog2(BATCH_COUNT + 1);    // fifo fill count
	localparam int TCNT_W = $clog2(BATCH_ENTRIES + 1);  // per-batch counts
	localparam int USE_W  = 8;                          // in-use counts, limits

	localparam int IN_W  = 16;
	localparam int OUT_W = 32;

	typedef enum logic [2:0] {
		OP_ACQUIRE = 3'd0,
		OP_PUSH    = 3'd1,
		OP_POP     = 3'd2,
		OP_RELEASE = 3'd3,
		OP_REVERT  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_LIMIT     = 2'd1,
		STAT_NO_FREE   = 2'd2,
		STAT_SUB_EMPTY = 2'd3
	} status_t;

	localparam logic [2:0] ADDR_LIMIT_USER     = 3'd0;
	localparam logic [2:0] ADDR_LIMIT_INTERNAL = 3'd4;
endpackage
`default_nettype wire

@@ rtl/core/wbbm_ram.sv @@
// Generic single-write, single-read RAM with bit write mask and registered read.
`default_nettype none
module wbbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [WIDTH-1:0]         wmask,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int i = 0; i < WIDTH; i++) begin
				if (wmask[i]) begin
					mem_q[waddr][i] <= wdata[i];
				end
			end
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/write_buffer_batch_manager.sv @@
// Write buffer batch manager: batch pool, free list and submit queue.
`default_nettype none
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata) carries one command per transfer:
//   acquire, push, pop, release or revert. Every command yields exactly one
//   result transfer on the output stream (m_tvalid/m_tready/m_tdata) with the
//   status, the granted entry, the popped batch and both in-use counts.
//   Each command is accepted in the idle state, which launches the
//   synchronous reads (entry class row, free list head, submit queue head);
//   the execute state then updates state from the read data and loads the
//   result register. A new command is accepted only after the last one has
//   left the execute state, and the result is valid once the result register
//   has been loaded at the end of the execute state.
//   The result sits in an output register: a new command is taken while the
//   previous result waits. When the receiver stalls, the command in flight
//   holds in its execute cycle until the output register frees up.
//   Limits for user and internal writes are set through the APB port at
//   byte addresses 0 and 4; write them only while the block is idle.
//   Reset clears all counters, empties the submit queue, closes the open
//   batch and fills the free list with batches 0 upward. No clearing pass
//   runs: the free list slots not yet written read as their own index.
module write_buffer_batch_manager (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// operation[2:0], entry_type[3], entry_index[10:4], batch_index[14:11]
	input  wire logic [wbbm_pkg::IN_W-1:0] s_tdata,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// status[1:0], granted_entry[8:2], popped_batch[12:9],
	// user_in_use[20:13], internal_in_use[28:21]
	output logic [wbbm_pkg::OUT_W-1:0]     m_tdata,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [2:0]                paddr,
	input  wire logic [31:0]               pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import wbbm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;

	// Configuration
	logic [USE_W-1:0] limit_user_q, limit_internal_q;

	// Command captured at transfer
	logic [2:0]    op_s1;
	logic          type_s1;
	logic [EW-1:0] eidx_s1;
	logic [BW-1:0] bidx_s1;

	// Batch bookkeeping in flops
	logic [TCNT_W-1:0] taken_q [BATCH_COUNT];
	logic [TCNT_W-1:0] ready_q [BATCH_COUNT];
	logic [USE_W-1:0]  use_q   [2];
	logic              open_v_q;
	logic [BW-1:0]     open_b_q;

	// FIFO pointers; free slots not yet written read as their own index
	logic [BW-1:0]          fhead_q, shead_q;
	logic [FCNT_W-1:0]      fcnt_q, scnt_q;
	logic [BATCH_COUNT-1:0] fwritten_q;

	// Output register
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic fire;
	assign fire = (state_q == ST_EXEC) && (!out_valid_q || m_tready);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// APB
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		prdata = '0;
		prdata[USE_W-1:0] = paddr[2] ? limit_internal_q : limit_user_q;
	end

	// Memories
	logic [BW-1:0]            cls_raddr;
	logic [BATCH_ENTRIES-1:0] cls_rdata, cls_wmask, cls_wdata;
	logic                     cls_we;
	logic [BW-1:0]            cls_waddr;
	logic [BW-1:0]            free_rdata, sub_rdata;
	logic                     free_we, sub_we;
	logic [BW-1:0]            free_waddr, sub_waddr, free_wdata, sub_wdata;

	assign cls_raddr = (state_q == ST_IDLE) ? s_tdata[14:11] : bidx_s1;

	wbbm_ram #(.WIDTH(BATCH_ENTRIES), .DEPTH(BATCH_COUNT)) u_class_ram (
		.clk(clk), .we(cls_we), .waddr(cls_waddr), .wdata(cls_wdata),
		.wmask(cls_wmask), .raddr(cls_raddr), .rdata(cls_rdata)
	);
	wbbm_ram #(.WIDTH(BW), .DEPTH(BATCH_COUNT)) u_free_ram (
		.clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
		.wmask({BW{1'b1}}), .raddr(fhead_q), .rdata(free_rdata)
	);
	wbbm_ram #(.WIDTH(BW), .DEPTH(BATCH_COUNT)) u_submit_ram (
		.clk(clk), .we(sub_we), .waddr(sub_waddr), .wdata(sub_wdata),
		.wmask({BW{1'b1}}), .raddr(shead_q), .rdata(sub_rdata)
	);

	// Execute: combinational next state of one command
	status_t           st;
	logic [EW-1:0]     granted;
	logic [BW-1:0]     popped;
	logic [USE_W-1:0]  use_n [2];
	logic              open_v_n;
	logic [BW-1:0]     open_b_n;
	logic [BW-1:0]     fhead_n, shead_n;
	logic [FCNT_W-1:0] fcnt_n, scnt_n;
	logic              taken_we, ready_we, clr_we;
	logic [BW-1:0]     taken_b, ready_b;
	logic [TCNT_W-1:0] taken_v, ready_v;

	logic [USE_W-1:0]  lim;
	logic [BW-1:0]     b, free_head_val, eb;
	logic [TCNT_W-1:0] t, ones;
	logic [FCNT_W:0]   ftail, stail;

	always_comb begin
		st = STAT_OK;
		granted = '0;
		popped = '0;
		use_n[0] = use_q[0];
		use_n[1] = use_q[1];
		open_v_n = open_v_q;
		open_b_n = open_b_q;
		fhead_n = fhead_q;
		shead_n = shead_q;
		fcnt_n = fcnt_q;
		scnt_n = scnt_q;
		taken_we = 1'b0;
		ready_we = 1'b0;
		clr_we = 1'b0;
		taken_b = '0;
		ready_b = '0;
		taken_v = '0;
		ready_v = '0;
		cls_we = 1'b0;
		cls_waddr = '0;
		cls_wmask = '0;
		cls_wdata = {BATCH_ENTRIES{type_s1}};
		free_we = 1'b0;
		free_wdata = bidx_s1;
		sub_we = 1'b0;
		sub_wdata = bidx_s1;
		b = '0;
		t = '0;
		eb = BW'(eidx_s1 / BATCH_ENTRIES);
		ones = '0;
		lim = type_s1 ? limit_internal_q : limit_user_q;
		free_head_val = fwritten_q[fhead_q] ? free_rdata : fhead_q;

		// Tail slots, wrapped
		ftail = (FCNT_W+1)'(fhead_q) + (FCNT_W+1)'(fcnt_q);
		if (ftail >= (FCNT_W+1)'(BATCH_COUNT))
			ftail = ftail - (FCNT_W+1)'(BATCH_COUNT);
		stail = (FCNT_W+1)'(shead_q) + (FCNT_W+1)'(scnt_q);
		if (stail >= (FCNT_W+1)'(BATCH_COUNT))
			stail = stail - (FCNT_W+1)'(BATCH_COUNT);
		free_waddr = ftail[BW-1:0];
		sub_waddr = stail[BW-1:0];

		for (int i = 0; i < BATCH_ENTRIES; i++)
			ones = ones + TCNT_W'(cls_rdata[i]);

		unique case (op_s1)
			OP_ACQUIRE: begin
				if (use_q[type_s1] >= lim) begin
					st = STAT_LIMIT;
				end else if (!open_v_q && fcnt_q == '0) begin
					st = STAT_NO_FREE;
				end else begin
					b = open_v_q ? open_b_q : free_head_val;
					if (!open_v_q) begin
						fhead_n = (fhead_q == BW'(BATCH_COUNT - 1)) ? '0 : fhead_q + 1'b1;
						fcnt_n = fcnt_q - 1'b1;
					end
					open_b_n = b;
					t = (taken_q[b] >= TCNT_W'(BATCH_ENTRIES)) ? '0 : taken_q[b];
					granted = EW'(b) * EW'(BATCH_ENTRIES) + EW'(t);
					taken_we = 1'b1;
					taken_b = b;
					taken_v = t + 1'b1;
					open_v_n = (taken_v < TCNT_W'(BATCH_ENTRIES));
					cls_we = 1'b1;
					cls_waddr = b;
					cls_wmask = BATCH_ENTRIES'(1) << t;
					if (use_q[type_s1] != '1)
						use_n[type_s1] = use_q[type_s1] + 1'b1;
				end
			end
			OP_PUSH: begin
				if ({1'b0, eidx_s1} < (EW+1)'(TOTAL_ENTRIES) &&
				    ready_q[eb] < TCNT_W'(BATCH_ENTRIES)) begin
					ready_we = 1'b1;
					ready_b = eb;
					ready_v = ready_q[eb] + 1'b1;
					if (ready_v == TCNT_W'(BATCH_ENTRIES) &&
					    scnt_q < FCNT_W'(BATCH_COUNT)) begin
						sub_we = 1'b1;
						sub_wdata = eb;
						scnt_n = scnt_q + 1'b1;
					end
				end
			end
			OP_POP: begin
				if (scnt_q == '0) begin
					st = STAT_SUB_EMPTY;
				end else begin
					popped = sub_rdata;
					shead_n = (shead_q == BW'(BATCH_COUNT - 1)) ? '0 : shead_q + 1'b1;
					scnt_n = scnt_q - 1'b1;
				end
			end
			OP_RELEASE: begin
				if ({1'b0, bidx_s1} < (BW+1)'(BATCH_COUNT)) begin
					clr_we = 1'b1;
					// Saturating decrement by the count of each class
					if (use_q[1] > USE_W'(ones))
						use_n[1] = use_q[1] - USE_W'(ones);
					else
						use_n[1] = '0;
					if (use_q[0] > USE_W'(TCNT_W'(BATCH_ENTRIES) - ones))
						use_n[0] = use_q[0] - USE_W'(TCNT_W'(BATCH_ENTRIES) - ones);
					else
						use_n[0] = '0;
					if (fcnt_q < FCNT_W'(BATCH_COUNT)) begin
						free_we = 1'b1;
						fcnt_n = fcnt_q + 1'b1;
					end
				end
			end
			OP_REVERT: begin
				if ({1'b0, bidx_s1} < (BW+1)'(BATCH_COUNT) &&
				    scnt_q < FCNT_W'(BATCH_COUNT)) begin
					sub_we = 1'b1;
					scnt_n = scnt_q + 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Commit only on the execute cycle that loads the result
		if (!fire) begin
			cls_we = 1'b0;
			free_we = 1'b0;
			sub_we = 1'b0;
		end
	end

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			limit_user_q <= USE_W'(128);
			limit_internal_q <= USE_W'(128);
			for (int i = 0; i < BATCH_COUNT; i++) begin
				taken_q[i] <= '0;
				ready_q[i] <= '0;
			end
			use_q[0] <= '0;
			use_q[1] <= '0;
			open_v_q <= 1'b0;
			open_b_q <= '0;
			fhead_q <= '0;
			fcnt_q <= FCNT_W'(BATCH_COUNT);
			fwritten_q <= '0;
			shead_q <= '0;
			scnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2])
					limit_internal_q <= pwdata[USE_W-1:0];
				else
					limit_user_q <= pwdata[USE_W-1:0];
			end
			// Load on fire, drop once the receiver takes it
			out_valid_q <= fire || (out_valid_q && !m_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (fire) begin
						state_q <= ST_IDLE;
						use_q[0] <= use_n[0];
						use_q[1] <= use_n[1];
						open_v_q <= open_v_n;
						open_b_q <= open_b_n;
						fhead_q <= fhead_n;
						fcnt_q <= fcnt_n;
						shead_q <= shead_n;
						scnt_q <= scnt_n;
						if (free_we)
							fwritten_q[free_waddr] <= 1'b1;
						if (taken_we)
							taken_q[taken_b] <= taken_v;
						if (ready_we)
							ready_q[ready_b] <= ready_v;
						if (clr_we) begin
							taken_q[bidx_s1] <= '0;
							ready_q[bidx_s1] <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: capture command, load result
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= s_tdata[2:0];
			type_s1 <= s_tdata[3];
			eidx_s1 <= s_tdata[10:4];
			bidx_s1 <= s_tdata[14:11];
		end
		if (fire) begin
			out_data_q <= {3'b000, use_n[1], use_n[0], popped, granted, st};
		end
	end

	// Checks
	a_free_cnt : assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= FCNT_W'(BATCH_COUNT))
		else $error("free list count overflow");
	a_sub_cnt : assert property (@(posedge clk) disable iff (!arst_n)
		scnt_q <= FCNT_W'(BATCH_COUNT))
		else $error("submit queue count overflow");
	a_result_src : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result loaded outside execute");
	a_one_result : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && out_valid_q && !m_tready) |=> state_q == ST_EXEC)
		else $error("command retired while result stalled");
endmodule
`default_nettype wire

@@ dv/write_buffer_batch_manager_checker.sv @@
// Command/result checker for the write buffer batch manager: predicts and compares results.
module write_buffer_batch_manager_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [wbbm_pkg::IN_W-1:0]          s_tdata,
	input  wire logic                               s_tvalid,
	input  wire logic                               s_tready,
	input  wire logic [wbbm_pkg::OUT_W-1:0]         m_tdata,
	input  wire logic                               m_tvalid,
	input  wire logic                               m_tready,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic                               pready,
	input  wire logic [2:0]                         paddr,
	input  wire logic [31:0]                        pwdata,
	output int                                      errors,
	output int                                      pending,
	output logic [wbbm_pkg::TOTAL_ENTRIES-1:0]      written
);
	import wbbm_pkg::*;

	typedef struct packed {
		status_t           status;
		logic [EW-1:0]     granted;
		logic [BW-1:0]     popped;
		logic [USE_W-1:0]  user_cnt;
		logic [USE_W-1:0]  int_cnt;
	} outcome_t;

	outcome_t outcome_q[$];

	// shadow of the pool
	logic [USE_W-1:0] lim [2];
	logic             cls [TOTAL_ENTRIES];
	int               taken [BATCH_COUNT];
	int               ready [BATCH_COUNT];
	int               held [2];
	logic [BW-1:0]    free_slot [BATCH_COUNT];
	int               free_head, free_cnt;
	logic [BW-1:0]    sub_slot [BATCH_COUNT];
	int               sub_head, sub_cnt;
	logic             open_v;
	int               open_b;

	function automatic void free_put(int b);
		if (free_cnt < BATCH_COUNT) begin
			free_slot[(free_head + free_cnt) % BATCH_COUNT] = b[BW-1:0];
			free_cnt++;
		end
	endfunction

	function automatic void sub_put(int b);
		if (sub_cnt < BATCH_COUNT) begin
			sub_slot[(sub_head + sub_cnt) % BATCH_COUNT] = b[BW-1:0];
			sub_cnt++;
		end
	endfunction

	function automatic outcome_t apply_command(logic [IN_W-1:0] cmd);
		outcome_t   o;
		logic [2:0] op;
		int         kind, eidx, bidx, b, g;
		op   = cmd[2:0];
		kind = cmd[3];
		eidx = cmd[10:4];
		bidx = cmd[14:11];
		o    = '0;
		o.status = STAT_OK;
		case (op)
			OP_ACQUIRE: begin
				if (held[kind] >= lim[kind]) begin
					o.status = STAT_LIMIT;
				end else if (!open_v && free_cnt == 0) begin
					o.status = STAT_NO_FREE;
				end else begin
					if (!open_v) begin
						open_b    = free_slot[free_head];
						free_head = (free_head + 1) % BATCH_COUNT;
						free_cnt--;
						open_v    = 1'b1;
					end
					b = open_b;
					if (taken[b] >= BATCH_ENTRIES) taken[b] = 0;
					g = b * BATCH_ENTRIES + taken[b];
					taken[b]++;
					if (taken[b] >= BATCH_ENTRIES) open_v = 1'b0;
					cls[g]    = kind[0];
					written[g] <= 1'b1;
					if (held[kind] < 255) held[kind]++;
					o.granted = g[EW-1:0];
				end
			end
			OP_PUSH: begin
				if (eidx < TOTAL_ENTRIES) begin
					b = eidx / BATCH_ENTRIES;
					if (ready[b] < BATCH_ENTRIES) begin
						ready[b]++;
						if (ready[b] == BATCH_ENTRIES) sub_put(b);
					end
				end
			end
			OP_POP: begin
				if (sub_cnt == 0) begin
					o.status = STAT_SUB_EMPTY;
				end else begin
					o.popped = sub_slot[sub_head];
					sub_head = (sub_head + 1) % BATCH_COUNT;
					sub_cnt--;
				end
			end
			OP_RELEASE: begin
				if (bidx < BATCH_COUNT) begin
					ready[bidx] = 0;
					taken[bidx] = 0;
					for (int i = 0; i < BATCH_ENTRIES; i++) begin
						g = cls[bidx * BATCH_ENTRIES + i];
						if (held[g] > 0) held[g]--;
					end
					free_put(bidx);
				end
			end
			OP_REVERT: begin
				if (bidx < BATCH_COUNT) sub_put(bidx);
			end
			default: ;
		endcase
		o.user_cnt = held[0][USE_W-1:0];
		o.int_cnt  = held[1][USE_W-1:0];
		return o;
	endfunction

	function automatic void note_mismatch(string field, int want, int got);
		if (errors < 10)
			$display("mismatch %s: expected %0d, got %0d", field, want, got);
		errors++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want, got;
		if (!arst_n) begin
			lim[0] = 8'd128;
			lim[1] = 8'd128;
			foreach (cls[i]) cls[i] = 1'b0;
			foreach (taken[i]) begin
				taken[i] = 0;
				ready[i] = 0;
				free_slot[i] = i[BW-1:0];
				sub_slot[i] = '0;
			end
			held[0] = 0;
			held[1] = 0;
			free_head = 0;
			free_cnt  = BATCH_COUNT;
			sub_head  = 0;
			sub_cnt   = 0;
			open_v    = 1'b0;
			open_b    = 0;
			outcome_q.delete();
			written <= '0;
			errors  = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_LIMIT_USER) lim[0] = pwdata[USE_W-1:0];
				else if (paddr == ADDR_LIMIT_INTERNAL) lim[1] = pwdata[USE_W-1:0];
			end
			// check the result first: anything accepted now is newer
			if (m_tvalid && m_tready) begin
				got = {status_t'(m_tdata[1:0]), m_tdata[8:2], m_tdata[12:9],
					m_tdata[20:13], m_tdata[28:21]};
				if (outcome_q.size() == 0) begin
					note_mismatch("unexpected result, status", -1, got.status);
				end else begin
					want = outcome_q.pop_front();
					if (want.status !== got.status)
						note_mismatch("status", want.status, got.status);
					if (want.granted !== got.granted)
						note_mismatch("granted_entry", want.granted, got.granted);
					if (want.popped !== got.popped)
						note_mismatch("popped_batch", want.popped, got.popped);
					if (want.user_cnt !== got.user_cnt)
						note_mismatch("user_in_use", want.user_cnt, got.user_cnt);
					if (want.int_cnt !== got.int_cnt)
						note_mismatch("internal_in_use", want.int_cnt, got.int_cnt);
				end
			end
			if (s_tvalid && s_tready)
				outcome_q.push_back(apply_command(s_tdata));
			pending <= outcome_q.size();
		end
	end

	// leftovers at the end are failures too
	function automatic int leftover();
		return outcome_q.size();
	endfunction
endmodule

@@ dv/write_buffer_batch_manager_tb.sv @@
// Testbench top for the write buffer batch manager: stimulus, handshakes and verdict.
module write_buffer_batch_manager_tb;
	import wbbm_pkg::*;

	localparam logic [2:0] OP_UNDEF_LO = 3'd5;
	localparam logic [2:0] OP_UNDEF_HI = 3'd7;
	localparam int         IDLE_LIMIT  = 5000;
	localparam logic       KIND_USER   = 1'b0;
	localparam logic       KIND_INT    = 1'b1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	int                errors;
	int                pending;
	logic [TOTAL_ENTRIES-1:0] written;

	// steady: no idling on either side for this stretch
	logic              steady = 1'b0;
	int                stall_left = 0;
	int                idle_cycles = 0;
	int                push_cursor = 0;

	write_buffer_batch_manager uut (
		.clk, .arst_n, .s_tdata, .s_tvalid, .s_tready, .m_tdata, .m_tvalid, .m_tready,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	write_buffer_batch_manager_checker chk (
		.clk, .arst_n, .s_tdata, .s_tvalid, .s_tready, .m_tdata, .m_tvalid, .m_tready,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.errors, .pending, .written
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(20, 40);
	endfunction

	// Receiver side: stall at random, hold ready low for the chosen stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready   <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	// Watchdog: count cycles with no transfer on either stream.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [IN_W-1:0] cmd(logic [2:0] op, logic kind,
			logic [EW-1:0] eidx, logic [BW-1:0] bidx);
		return {1'b0, bidx, eidx, kind, op};
	endfunction

	// Present one command and hold it until the transfer happens.
	task automatic send(input logic [IN_W-1:0] data);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Drop valid and wait until every result has come back, then let the pipe settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [7:0] user_lim, input logic [7:0] int_lim);
		drain();
		reg_write(ADDR_LIMIT_USER, user_lim);
		reg_write(ADDR_LIMIT_INTERNAL, int_lim);
	endtask

	// One random command, weighted toward the acquire/push/pop/release flow.
	task automatic random_command();
		int          r, b;
		logic [EW-1:0] e;
		r = $urandom_range(0, 99);
		if (r < 34) begin
			send(cmd(OP_ACQUIRE, 1'($urandom_range(0, 1)), EW'($urandom), BW'($urandom)));
		end else if (r < 64) begin
			// walk entries in order so batches fill up; sometimes hit anywhere
			if ($urandom_range(0, 9) < 7) begin
				e = push_cursor[EW-1:0];
				push_cursor = (push_cursor + 1) % TOTAL_ENTRIES;
			end else begin
				e = EW'($urandom);
			end
			send(cmd(OP_PUSH, 1'($urandom_range(0, 1)), e, BW'($urandom)));
		end else if (r < 76) begin
			send(cmd(OP_POP, 1'($urandom_range(0, 1)), EW'($urandom), BW'($urandom)));
		end else if (r < 91) begin
			// release only batches whose every entry has had a class written
			b = $urandom_range(0, BATCH_COUNT - 1);
			for (int k = 0; k < BATCH_COUNT && !(&written[b*BATCH_ENTRIES +: BATCH_ENTRIES]);
					k++)
				b = (b + 1) % BATCH_COUNT;
			if (&written[b*BATCH_ENTRIES +: BATCH_ENTRIES])
				send(cmd(OP_RELEASE, 1'($urandom_range(0, 1)), EW'($urandom), b[BW-1:0]));
			else
				send(cmd(OP_ACQUIRE, 1'($urandom_range(0, 1)), EW'($urandom),
					BW'($urandom)));
		end else if (r < 97) begin
			send(cmd(OP_REVERT, 1'($urandom_range(0, 1)), EW'($urandom), BW'($urandom)));
		end else begin
			send(cmd(3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)), 1'($urandom_range(0, 1)),
				EW'($urandom), BW'($urandom)));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty submit queue, unknown operations, reset limits.
		steady = 1'b1;
		send(cmd(OP_POP, KIND_USER, '0, '0));
		for (int op = OP_UNDEF_LO; op <= OP_UNDEF_HI; op++)
			send(cmd(op[2:0], KIND_INT, '1, '1));
		// Fill batch 0 with user writes, open batch 1 for an internal write.
		repeat (BATCH_ENTRIES) send(cmd(OP_ACQUIRE, KIND_USER, '0, '0));
		send(cmd(OP_ACQUIRE, KIND_INT, '1, '1));
		for (int i = 0; i < BATCH_ENTRIES; i++)
			send(cmd(OP_PUSH, KIND_USER, i[EW-1:0], '0));
		send(cmd(OP_PUSH, KIND_USER, '0, '0));           // excess push
		send(cmd(OP_PUSH, KIND_USER, '1, '0));           // top entry position
		send(cmd(OP_POP, KIND_USER, '0, '0));
		send(cmd(OP_REVERT, KIND_USER, '0, '1));
		send(cmd(OP_POP, KIND_USER, '0, '0));
		send(cmd(OP_RELEASE, KIND_USER, '0, '0));
		steady = 1'b0;

		// Limit of zero refuses both classes.
		set_limits(8'd0, 8'd0);
		send(cmd(OP_ACQUIRE, KIND_USER, '0, '0));
		send(cmd(OP_ACQUIRE, KIND_INT, '0, '0));

		// Widest limits: run the pool dry, then release and reopen batch 0.
		set_limits(8'd255, 8'd255);
		repeat (TOTAL_ENTRIES + 2) send(cmd(OP_ACQUIRE, 1'($urandom_range(0, 1)), '0, '0));
		drain();
		send(cmd(OP_RELEASE, KIND_USER, '0, '0));
		send(cmd(OP_ACQUIRE, KIND_INT, '0, '0));
		drain();
		send(cmd(OP_RELEASE, KIND_USER, '0, '0));        // batch 0 is open here
		send(cmd(OP_ACQUIRE, KIND_USER, '0, '0));
		for (int b = 1; b < BATCH_COUNT; b++)
			send(cmd(OP_RELEASE, KIND_INT, '0, b[BW-1:0]));
		repeat (BATCH_COUNT + 2) send(cmd(OP_REVERT, KIND_USER, '0, BW'($urandom)));

		// Random phases under changing limits; every drain is a full pause.
		set_limits(8'd128, 8'd128);
		repeat (300) random_command();
		set_limits(8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)));
		steady = 1'b1;
		repeat (150) random_command();
		steady = 1'b0;
		repeat (150) random_command();
		set_limits(8'd3, 8'd5);
		repeat (250) random_command();
		set_limits(8'd255, 8'd128);
		repeat (150) random_command();

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0 && chk.leftover() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

@@ write_buffer_batch_manager.f @@
rtl/core/wbbm_pkg.sv
rtl/core/wbbm_ram.sv
rtl/core/write_buffer_batch_manager.sv
dv/write_buffer_batch_manager_checker.sv
dv/write_buffer_batch_manager_tb.sv
